### design/lbb_pkg.sv
// shared types, constants and helpers for the line box blur block
// no dependencies
package lbb_pkg;

    localparam int MAX_RADIUS      = 32;
    localparam int MAX_LINE_LENGTH = 4096;
    localparam int STORE_DEPTH     = 2 * MAX_RADIUS;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int POS_W           = $clog2(MAX_LINE_LENGTH);
    localparam int J_W             = POS_W + 1;
    localparam int SUM_W           = 14;
    localparam int K_W             = 3;
    localparam int K_MAX           = $clog2(MAX_RADIUS);
    localparam int PX_W            = 24;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = QPTR_W + 1;

    localparam logic [K_W-1:0]   RADIUS_RESET = 3'd5;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(MAX_LINE_LENGTH - 1);

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       line_end_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       line_end_out;
    } t_out;

    // one classified pixel from the front part
    typedef struct packed {
        logic [PX_W-1:0]  px;
        logic [POS_W-1:0] pos;
        logic [K_W-1:0]   k;
        logic             last;
    } t_cmd;

    // one window advance in the back part
    typedef struct packed {
        logic [J_W-1:0]  j;
        logic [PX_W-1:0] px;
        logic [K_W-1:0]  k;
        logic            first;
        logic            lend;
    } t_op;

    function automatic logic [K_W-1:0] eff_log2(input logic [K_W-1:0] v);
        return (v > K_W'(K_MAX)) ? K_W'(K_MAX) : v;
    endfunction

endpackage

### design/line_box_blur_unit.sv
// top level: 1-d box blur over a line of rgb pixels, radius 2^k from the radius register
// throughput one pixel word per cycle while the result queue has room; a line end holds
// the queue head while the back sequencer flushes up to R results at the same rate; the
// result of pixel x follows x+R through front queue, advance stage and result queue
// reset: synchronous active low, clears queues, position and sums, radius exponent to 5;
// pixel store is not cleared
module line_box_blur_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  lbb_pkg::t_in  i_in,
    output logic          o_empty,
    input  logic          i_pop,
    output lbb_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_wdata
);
    import lbb_pkg::*;

    logic [K_W-1:0] r_radius;
    logic           head_valid, head_pop, out_write, out_full;
    t_cmd           head;
    t_out           out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    lbb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_in         (i_in),
        .i_radius     (r_radius),
        .i_pop        (head_pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    lbb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (head_pop),
        .i_out_full   (out_full),
        .o_out_write  (out_write),
        .o_out_data   (out_data)
    );

    lbb_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (out_write),
        .i_data  (out_data),
        .o_full  (out_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_out)
    );

endmodule

### design/lbb_front.sv
// front part: accepts pixels, tracks line position, latches radius, queues commands
// depends on lbb_pkg
module lbb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  lbb_pkg::t_in  i_in,
    input  logic [2:0]    i_radius,
    input  logic          i_pop,
    output logic          o_head_valid,
    output lbb_pkg::t_cmd o_head
);
    import lbb_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [POS_W-1:0]  r_pos;
    logic              accept, do_pop, last;
    t_cmd              cmd;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept       = i_push && !o_full;
    assign o_head_valid = (r_count != '0);
    assign do_pop       = i_pop && o_head_valid;
    assign o_head       = r_q[r_rd_ptr];

    // overlong lines end at the last position
    assign last = i_in.line_end_in || (r_pos == POS_LAST);

    always_comb begin
        cmd.px   = {i_in.red_in, i_in.green_in, i_in.blue_in};
        cmd.pos  = r_pos;
        cmd.k    = eff_log2(i_radius);
        cmd.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_pos    <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
                r_pos    <= last ? '0 : r_pos + POS_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({accept, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/lbb_back.sv
// back part: expands commands into window advances, keeps the pixel store and sums
// depends on lbb_pkg
module lbb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  lbb_pkg::t_cmd i_head,
    output logic          o_pop,
    input  logic          i_out_full,
    output logic          o_out_write,
    output lbb_pkg::t_out o_out_data
);
    import lbb_pkg::*;

    function automatic logic [SUM_W-1:0] next_sum(
        input logic [SUM_W-1:0] sum,
        input logic [7:0]       add_ch,
        input logic [7:0]       sub_ch,
        input logic [K_W-1:0]   k,
        input logic             first,
        input logic             emit
    );
        logic [SUM_W-1:0] base;
        logic [SUM_W-1:0] s;
        base = first ? (SUM_W'(add_ch) << k) : sum;
        s    = base + SUM_W'(add_ch);
        if (emit) begin
            s = s - SUM_W'(sub_ch);
        end
        return s;
    endfunction

    function automatic logic [7:0] avg(input logic [SUM_W-1:0] s, input logic [K_W-1:0] k);
        logic [SUM_W-1:0] t;
        t = s >> (k + K_W'(1));
        return t[7:0];
    endfunction

    logic [PX_W-1:0]  r_store [STORE_DEPTH];
    logic [PX_W-1:0]  r_rd;
    logic             r_flushing;
    logic [J_W-1:0]   r_j, r_jend;
    logic [PX_W-1:0]  r_fpx;
    logic [K_W-1:0]   r_fk;
    logic             r_b_valid;
    t_op              r_b;
    logic [SUM_W-1:0] r_red_sum, r_green_sum, r_blue_sum;
    logic [PX_W-1:0]  r_first;

    logic             go;
    logic             a_valid, a_wr;
    t_op              a_op;
    logic [J_W-1:0]   a_diff;
    logic [J_W-1:0]   b_r;
    logic             b_emit, b_use_store;
    logic [PX_W-1:0]  b_sub;
    logic [SUM_W-1:0] b_red, b_green, b_blue;

    assign go = !i_out_full;

    // stage a: pick the next advance, from the queue head or the line-end flush
    always_comb begin
        if (r_flushing) begin
            a_valid    = 1'b1;
            a_wr       = 1'b0;
            a_op.j     = r_j;
            a_op.px    = r_fpx;
            a_op.k     = r_fk;
            a_op.first = 1'b0;
            a_op.lend  = (r_j == r_jend);
        end else begin
            a_valid    = i_head_valid;
            a_wr       = 1'b1;
            a_op.j     = {1'b0, i_head.pos};
            a_op.px    = i_head.px;
            a_op.k     = i_head.k;
            a_op.first = (i_head.pos == '0);
            a_op.lend  = 1'b0;
        end
    end

    assign o_pop  = go && !r_flushing && i_head_valid;
    assign a_diff = a_op.j - (J_W'(2) << a_op.k);

    // read returns old data when it meets the write at full radius
    always_ff @(posedge i_clk) begin
        if (go && a_valid) begin
            r_rd <= r_store[a_diff[ADDR_W-1:0]];
            if (a_wr) begin
                r_store[a_op.j[ADDR_W-1:0]] <= a_op.px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flushing <= 1'b0;
            r_b_valid  <= 1'b0;
        end else if (go) begin
            r_b_valid <= a_valid;
            if (r_flushing) begin
                if (a_op.lend) begin
                    r_flushing <= 1'b0;
                end
            end else if (i_head_valid && i_head.last) begin
                r_flushing <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b <= a_op;
            if (r_flushing) begin
                r_j <= r_j + J_W'(1);
            end else begin
                r_j   <= {1'b0, i_head.pos} + J_W'(1);
                r_jend <= {1'b0, i_head.pos} + (J_W'(1) << i_head.k);
                r_fpx <= i_head.px;
                r_fk  <= i_head.k;
            end
        end
    end

    // stage b: update running sums and form the averaged pixel
    assign b_r         = J_W'(1) << r_b.k;
    assign b_emit      = (r_b.j >= b_r);
    assign b_use_store = (r_b.j >= (b_r << 1));
    assign b_sub       = b_use_store ? r_rd : r_first;

    assign b_red   = next_sum(r_red_sum,   r_b.px[23:16], b_sub[23:16], r_b.k, r_b.first, b_emit);
    assign b_green = next_sum(r_green_sum, r_b.px[15:8],  b_sub[15:8],  r_b.k, r_b.first, b_emit);
    assign b_blue  = next_sum(r_blue_sum,  r_b.px[7:0],   b_sub[7:0],   r_b.k, r_b.first, b_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_sum   <= '0;
            r_green_sum <= '0;
            r_blue_sum  <= '0;
            r_first     <= '0;
        end else if (go && r_b_valid) begin
            r_red_sum   <= b_red;
            r_green_sum <= b_green;
            r_blue_sum  <= b_blue;
            if (r_b.first) begin
                r_first <= r_b.px;
            end
        end
    end

    assign o_out_write = go && r_b_valid && b_emit;

    always_comb begin
        o_out_data.red_out      = avg(b_red, r_b.k);
        o_out_data.green_out    = avg(b_green, r_b.k);
        o_out_data.blue_out     = avg(b_blue, r_b.k);
        o_out_data.alpha_out    = ALPHA_OPAQUE;
        o_out_data.line_end_out = r_b.lend;
    end

endmodule

### design/lbb_out_queue.sv
// result queue that parts the back part from the consumer
// depends on lbb_pkg
module lbb_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_write,
    input  lbb_pkg::t_out i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output lbb_pkg::t_out o_data
);
    import lbb_pkg::*;

    t_out              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_wr, do_rd;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_write && !o_full;
    assign do_rd   = i_pop && !o_empty;
    assign o_data  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
